@@ sv/tcd_pkg.sv @@
// shared types, codes and helpers of the text charset detector
package tcd_pkg;

  // verdict character set codes
  typedef enum logic [1:0] {
    CS_BINARY  = 2'd0,
    CS_UTF8    = 2'd1,
    CS_UTF16BE = 2'd2,
    CS_UTF16LE = 2'd3
  } charset_e;

  // byte order mark lengths
  localparam logic [1:0] BOM_NONE  = 2'd0;
  localparam logic [1:0] BOM_UTF16 = 2'd2;
  localparam logic [1:0] BOM_UTF8  = 2'd3;

  // head signature found at the last byte
  typedef enum logic [2:0] {
    MARK_NONE  = 3'd0,
    MARK_SIG   = 3'd1,
    MARK_UTF8  = 3'd2,
    MARK_BE    = 3'd3,
    MARK_LE    = 3'd4
  } mark_e;

  // head signature bytes
  localparam logic [7:0] SIG_B0  = 8'd27;
  localparam logic [7:0] SIG_B1  = 8'h4c;
  localparam logic [7:0] SIG_B2  = 8'h4a;
  localparam logic [7:0] BOM8_B0 = 8'd239;
  localparam logic [7:0] BOM8_B1 = 8'd187;
  localparam logic [7:0] BOM8_B2 = 8'd191;
  localparam logic [7:0] BOM16_FE = 8'd254;
  localparam logic [7:0] BOM16_FF = 8'd255;

  // queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // classified byte event handed from front to back
  typedef struct packed {
    logic  scan;        // a position is scanned with this byte
    logic  even;        // scanned position is even
    logic  zero0;       // byte at the position is zero
    logic  zero1;       // byte after the position is zero
    logic  high;        // byte at the position is 0x80 or above
    logic  u8_seen;     // counted lead or ascii byte
    logic  u8_broken;   // invalid lead or incomplete sequence
    logic  last;        // final byte of the head
    mark_e mark;        // head signature, valid with last
  } scan_rec_t;

  function automatic logic is_tail(input logic [7:0] c);
    return c[7:6] == 2'b10;
  endfunction

endpackage

@@ sv/tcd_front.sv @@
// front: takes bytes, tracks the head and lookahead, classifies each scan position
module tcd_front #(
  parameter int unsigned SCAN_LIMIT = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // data_byte
  input  logic              s_axis_tlast,   // last_byte
  input  logic              full_i,
  output logic              push_o,
  output tcd_pkg::scan_rec_t rec_o
);
  import tcd_pkg::*;

  localparam int unsigned POS_W = $clog2(SCAN_LIMIT + 5);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(SCAN_LIMIT + 4);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       head_q [3];
  logic [7:0]       head_d [3];
  logic [7:0]       win_q  [4];
  logic [7:0]       win_d  [4];
  logic             accept;
  logic [7:0]       d0, d1, d2, d3, b, h0, h1, h2;
  logic             size2, size3;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && !full_i;
  assign push_o        = accept;
  assign b             = s_axis_tdata;

  // win_q[0] is the newest byte before this one
  assign d0 = win_q[3];
  assign d1 = win_q[2];
  assign d2 = win_q[1];
  assign d3 = win_q[0];

  assign h0 = (pos_q == POS_W'(0)) ? b : head_q[0];
  assign h1 = (pos_q == POS_W'(1)) ? b : head_q[1];
  assign h2 = (pos_q == POS_W'(2)) ? b : head_q[2];
  assign size2 = pos_q >= POS_W'(1);
  assign size3 = pos_q >= POS_W'(2);

  always_comb begin
    rec_o.scan  = (pos_q >= POS_W'(4)) && (pos_q != POS_MAX);
    rec_o.even  = !pos_q[0];
    rec_o.zero0 = d0 == 8'h00;
    rec_o.zero1 = d1 == 8'h00;
    rec_o.high  = d0[7];
    rec_o.last  = s_axis_tlast;
    rec_o.u8_seen   = 1'b0;
    rec_o.u8_broken = 1'b0;
    if (is_tail(d0)) begin
      rec_o.u8_seen = 1'b0;
    end else if (!d0[7]) begin
      rec_o.u8_seen = 1'b1;
    end else if (d0[7:5] == 3'b110 && is_tail(d1)) begin
      rec_o.u8_seen = 1'b1;
    end else if (d0[7:4] == 4'b1110 && is_tail(d1) && is_tail(d2)) begin
      rec_o.u8_seen = 1'b1;
    end else if (d0[7:3] == 5'b11110 && is_tail(d1) && is_tail(d2) && is_tail(d3)) begin
      rec_o.u8_seen = 1'b1;
    end else begin
      rec_o.u8_broken = 1'b1;
    end

    if (size3 && h0 == SIG_B0 && h1 == SIG_B1 && h2 == SIG_B2) begin
      rec_o.mark = MARK_SIG;
    end else if (size3 && h0 == BOM8_B0 && h1 == BOM8_B1 && h2 == BOM8_B2) begin
      rec_o.mark = MARK_UTF8;
    end else if (size2 && h0 == BOM16_FE && h1 == BOM16_FF) begin
      rec_o.mark = MARK_BE;
    end else if (size2 && h0 == BOM16_FF && h1 == BOM16_FE) begin
      rec_o.mark = MARK_LE;
    end else begin
      rec_o.mark = MARK_NONE;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    head_d = head_q;
    win_d  = win_q;
    if (accept) begin
      if (s_axis_tlast) begin
        pos_d  = '0;
        head_d = '{default: 8'h00};
        win_d  = '{default: 8'h00};
      end else begin
        pos_d     = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : pos_q;
        head_d[0] = h0;
        head_d[1] = h1;
        head_d[2] = h2;
        win_d[0]  = b;
        win_d[1]  = win_q[0];
        win_d[2]  = win_q[1];
        win_d[3]  = win_q[2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      head_q <= '{default: 8'h00};
      win_q  <= '{default: 8'h00};
    end else begin
      pos_q  <= pos_d;
      head_q <= head_d;
      win_q  <= win_d;
    end
  end

endmodule

@@ sv/tcd_queue.sv @@
// short queue of classified byte events between front and back
module tcd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tcd_pkg::scan_rec_t rec_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output tcd_pkg::scan_rec_t rec_o
);
  import tcd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  scan_rec_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ sv/tcd_back.sv @@
// back: accumulates scan counts and issues the verdict into an output register
module tcd_back #(
  parameter int unsigned SCAN_LIMIT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tcd_pkg::scan_rec_t rec_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata   // [1:0] charset, [3:2] bom_length
);
  import tcd_pkg::*;

  localparam int unsigned ZT_W = $clog2(SCAN_LIMIT + 1);
  localparam int unsigned EO_W = $clog2(SCAN_LIMIT / 2 + 2);

  logic [ZT_W-1:0] zt_q, zt_d;
  logic [EO_W-1:0] ev_q, ev_d, od_q, od_d;
  logic            asc_seen_q, asc_seen_d, asc_brk_q, asc_brk_d;
  logic            u8_seen_q, u8_seen_d, u8_brk_q, u8_brk_d;
  logic            out_vld_q, out_vld_d;
  charset_e        cs_q, cs_d;
  logic [1:0]      bom_q, bom_d;
  logic            out_free, ascii_ok, utf8_ok, few_zeros;

  assign out_free = !out_vld_q || m_axis_tready;
  assign pop_o    = valid_i && (!rec_i.last || out_free);

  // counts including the event being retired
  always_comb begin
    zt_d       = zt_q;
    ev_d       = ev_q;
    od_d       = od_q;
    asc_seen_d = asc_seen_q;
    asc_brk_d  = asc_brk_q;
    u8_seen_d  = u8_seen_q;
    u8_brk_d   = u8_brk_q;
    if (rec_i.scan) begin
      if (rec_i.zero0) zt_d = zt_q + ZT_W'(1);
      if (rec_i.even && rec_i.zero0) ev_d = ev_q + EO_W'(1);
      if (rec_i.even && rec_i.zero1) od_d = od_q + EO_W'(1);
      asc_seen_d = 1'b1;
      asc_brk_d  = asc_brk_q | rec_i.high;
      u8_seen_d  = u8_seen_q | rec_i.u8_seen;
      u8_brk_d   = u8_brk_q | rec_i.u8_broken;
    end
  end

  assign ascii_ok  = asc_seen_d && !asc_brk_d;
  assign utf8_ok   = u8_seen_d && !u8_brk_d;
  assign few_zeros = zt_d <= ZT_W'(1);

  always_comb begin
    bom_d = BOM_NONE;
    case (rec_i.mark)
      MARK_SIG:  cs_d = CS_BINARY;
      MARK_UTF8: begin
        cs_d  = CS_UTF8;
        bom_d = BOM_UTF8;
      end
      MARK_BE: begin
        cs_d  = CS_UTF16BE;
        bom_d = BOM_UTF16;
      end
      MARK_LE: begin
        cs_d  = CS_UTF16LE;
        bom_d = BOM_UTF16;
      end
      default: begin
        if ((ascii_ok || utf8_ok) && few_zeros) begin
          cs_d = CS_UTF8;
        end else if (ev_d != '0 && ev_d > od_d) begin
          cs_d = CS_UTF16BE;
        end else if (od_d != '0 && od_d >= ev_d) begin
          cs_d = CS_UTF16LE;
        end else if (utf8_ok) begin
          cs_d = CS_UTF8;
        end else begin
          cs_d = CS_BINARY;
        end
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (pop_o && rec_i.last) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zt_q       <= '0;
      ev_q       <= '0;
      od_q       <= '0;
      asc_seen_q <= 1'b0;
      asc_brk_q  <= 1'b0;
      u8_seen_q  <= 1'b0;
      u8_brk_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (pop_o) begin
        if (rec_i.last) begin
          zt_q       <= '0;
          ev_q       <= '0;
          od_q       <= '0;
          asc_seen_q <= 1'b0;
          asc_brk_q  <= 1'b0;
          u8_seen_q  <= 1'b0;
          u8_brk_q   <= 1'b0;
        end else begin
          zt_q       <= zt_d;
          ev_q       <= ev_d;
          od_q       <= od_d;
          asc_seen_q <= asc_seen_d;
          asc_brk_q  <= asc_brk_d;
          u8_seen_q  <= u8_seen_d;
          u8_brk_q   <= u8_brk_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && rec_i.last) begin
      cs_q  <= cs_d;
      bom_q <= bom_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, bom_q, cs_q};

endmodule

@@ sv/text_charset_detector.sv @@
// top level of the text charset detector
// the block takes the leading bytes of a file, one byte per transfer on the slave
// stream with tlast on the final byte, and returns one verdict transfer on the
// master stream for each head: a character set (binary, utf-8, utf-16 big or
// little endian) and the byte order mark length to skip (0, 2 or 3). a bytecode
// signature or a byte order mark in the first bytes decides the verdict; otherwise
// every position below both length minus four and SCAN_LIMIT is scanned with
// three bytes of lookahead, and zero, ascii and utf-8 lead statistics pick the
// verdict. the block takes one byte per clock cycle: the front tracks position
// and lookahead and classifies each byte in the cycle it is accepted, a
// two-entry queue carries the events, and the back retires one event per cycle
// into its counters, a final event only once the output register is free. the
// verdict passes through the queue into an output register on the master stream,
// held there so bytes of the next head keep flowing while it waits to be taken;
// only when the next head's final byte reaches the back before the verdict is
// taken does the queue fill and the slave stream stall. there is no reset sweep;
// the block is ready right after reset
module text_charset_detector #(
  parameter int unsigned SCAN_LIMIT = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte stream in
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  // verdict stream out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] charset, [3:2] bom_length, rest zero
);
  import tcd_pkg::*;

  scan_rec_t push_rec, pop_rec;
  logic      push, full, pop, q_valid;

  // front: byte position, head bytes and lookahead window
  tcd_front #(
    .SCAN_LIMIT(SCAN_LIMIT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .full_i       (full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  // decouples the byte side from the verdict side
  tcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rec_o  (pop_rec)
  );

  // back: counters, verdict and output register
  tcd_back #(
    .SCAN_LIMIT(SCAN_LIMIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .rec_i        (pop_rec),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
